// ===== design/ogcf_pkg.sv =====
// Shared widths, codes and defaults for the occupancy grid circle fill unit.
`default_nettype none

package ogcf_pkg;

    // Field widths
    localparam int COORD_W   = 10;
    localparam int RADIUS_W  = 6;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Stream packing
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;
    localparam int X_LSB     = 0;
    localparam int Y_LSB     = COORD_W;
    localparam int R_LSB     = 2 * COORD_W;

    // Parameter defaults
    localparam int DEF_MAP_MAX_WIDTH  = 256;
    localparam int DEF_MAP_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS     = 63;

    // Register reset values
    localparam logic [DIM_W-1:0] MAP_WIDTH_RST  = DIM_W'(256);
    localparam logic [DIM_W-1:0] MAP_HEIGHT_RST = DIM_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 1'b0,
        CFG_MAP_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [S_TUSER_W-1:0] {
        OP_QUERY = 1'b0,
        OP_DRAW  = 1'b1
    } op_t;

endpackage

`default_nettype wire

// ===== design/ogcf_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module ogcf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // rdata holds between reads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/occupancy_grid_circle_fill_unit.sv =====
// Top level: one-bit occupancy map with cell queries and filled-circle drawing.
// Query: one RAM read, then the result register is loaded once the result slot
//   is free; a new input beat is taken only after that result has been loaded.
// Draw: scans the (2r+1)^2 bounding square, one candidate cell per cycle through the
//   single RAM port; the result beat follows after that.
// Reset (rst_n low, async): control cleared, registers to 256 x 256, then a
//   clearing pass writes all 2^(clog2(W)+clog2(H)) map bits (65536 at defaults) to
//   free; no input beat is taken meanwhile, config writes are.
`default_nettype none

module occupancy_grid_circle_fill_unit
    import ogcf_pkg::*;
#(
    parameter int MAP_MAX_WIDTH  = DEF_MAP_MAX_WIDTH,
    parameter int MAP_MAX_HEIGHT = DEF_MAP_MAX_HEIGHT,
    parameter int MAX_RADIUS     = DEF_MAX_RADIUS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // Configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,

    // Input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // x_coord[9:0], y_coord[19:10], radius[25:20]
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // operation[0]

    // Result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // occupied[0], in_bounds[1]
);

    // Address is {row, column}; rows are a power of two apart.
    localparam int XW     = $clog2(MAP_MAX_WIDTH);
    localparam int YW     = $clog2(MAP_MAX_HEIGHT);
    localparam int AW     = XW + YW;
    localparam int DEPTH  = 1 << AW;
    localparam int SUM_W  = COORD_W + 2;
    localparam int DMAX   = (MAP_MAX_WIDTH > MAP_MAX_HEIGHT) ? MAP_MAX_WIDTH : MAP_MAX_HEIGHT;
    localparam int DIMC_W = $clog2(DMAX + 1);
    localparam int CMP_W  = ((DIMC_W > SUM_W) ? DIMC_W : SUM_W) + 1;
    localparam int SQ_W   = 2 * RADIUS_W;
    localparam int D_W    = RADIUS_W + 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_RESP
    } state_t;

    // Control state
    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIM_W-1:0]  map_width_reg, map_width_next;
    logic [DIM_W-1:0]  map_height_reg, map_height_next;

    // Item payload
    logic signed [SUM_W-1:0] cx_reg, cx_next;
    logic signed [SUM_W-1:0] cy_reg, cy_next;
    logic [RADIUS_W-1:0]     r_reg, r_next;
    logic signed [D_W-1:0]   dx_reg, dx_next;
    logic signed [D_W-1:0]   dy_reg, dy_next;
    logic [SQ_W-1:0]         dx_sq_reg, dx_sq_next;
    logic [SQ_W-1:0]         dy_sq_reg, dy_sq_next;
    logic [SQ_W-1:0]         rsq_reg, rsq_next;
    logic                    is_draw_reg, is_draw_next;
    logic                    in_bounds_reg, in_bounds_next;
    logic                    out_occ_reg, out_occ_next;
    logic                    out_inb_reg, out_inb_next;

    // Combinational
    logic                    in_beat;
    logic                    load_out;
    logic signed [COORD_W-1:0] in_x, in_y;
    logic signed [SUM_W-1:0] in_xs, in_ys;
    logic [RADIUS_W-1:0]     in_r, r_sat;
    logic [SQ_W-1:0]         rsq_in;
    logic signed [D_W-1:0]   r_signed;
    logic [CMP_W-1:0]        eff_w, eff_h;
    logic                    center_in;
    logic signed [SUM_W-1:0] cell_x, cell_y;
    logic                    cell_in;
    logic                    disc_hit;
    logic                    dx_last, dy_last;
    logic                    ram_en, ram_we;
    logic [AW-1:0]           ram_addr;
    logic [0:0]              ram_wdata, ram_rdata;

    function automatic logic cell_in_map(
        input logic signed [SUM_W-1:0] x,
        input logic signed [SUM_W-1:0] y,
        input logic [CMP_W-1:0]        w,
        input logic [CMP_W-1:0]        h
    );
        logic xin, yin;
        xin = !x[SUM_W-1] && (CMP_W'($unsigned(x)) < w);
        yin = !y[SUM_W-1] && (CMP_W'($unsigned(y)) < h);
        return xin && yin;
    endfunction

    // (d+1)^2 = d^2 + 2d + 1
    function automatic logic [SQ_W-1:0] sq_step(
        input logic [SQ_W-1:0]       sq,
        input logic signed [D_W-1:0] d
    );
        logic signed [SQ_W+1:0] t;
        t = $signed({2'b00, sq}) + (SQ_W+2)'($signed({d, 1'b1}));
        return t[SQ_W-1:0];
    endfunction

    // Config takes every beat; registers beyond the map maximum saturate on use.
    assign cfg_ready = 1'b1;

    assign eff_w = (CMP_W'(map_width_reg) > CMP_W'(MAP_MAX_WIDTH))
                 ? CMP_W'(MAP_MAX_WIDTH) : CMP_W'(map_width_reg);
    assign eff_h = (CMP_W'(map_height_reg) > CMP_W'(MAP_MAX_HEIGHT))
                 ? CMP_W'(MAP_MAX_HEIGHT) : CMP_W'(map_height_reg);

    // Input unpack
    assign in_x   = $signed(s_tdata[X_LSB +: COORD_W]);
    assign in_y   = $signed(s_tdata[Y_LSB +: COORD_W]);
    assign in_r   = s_tdata[R_LSB +: RADIUS_W];
    assign in_xs  = SUM_W'(in_x);
    assign in_ys  = SUM_W'(in_y);
    assign r_sat  = (32'(in_r) > 32'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : in_r;
    assign rsq_in = SQ_W'(r_sat) * SQ_W'(r_sat);
    assign center_in = cell_in_map(in_xs, in_ys, eff_w, eff_h);

    // Input is taken only while idle; a waiting result does not block it.
    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    // Draw scan: current candidate cell
    assign r_signed = $signed({1'b0, r_reg});
    assign cell_x   = cx_reg + SUM_W'(dx_reg);
    assign cell_y   = cy_reg + SUM_W'(dy_reg);
    assign cell_in  = cell_in_map(cell_x, cell_y, eff_w, eff_h);
    assign disc_hit = ((SQ_W+1)'(dx_sq_reg) + (SQ_W+1)'(dy_sq_reg)) <= (SQ_W+1)'(rsq_reg);
    assign dx_last  = (dx_reg == r_signed);
    assign dy_last  = (dy_reg == r_signed);

    // Result register loads once the slot is empty or being drained.
    assign load_out = (state_reg == ST_RESP) && (!out_valid_reg || m_tready);

    // RAM port: clearing pass, draw writes, or query read
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = {in_ys[YW-1:0], in_xs[XW-1:0]};
        ram_wdata = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = 1'b0;
            end
            ST_DRAW:
            begin
                ram_en    = disc_hit && cell_in;
                ram_we    = disc_hit && cell_in;
                ram_addr  = {cell_y[YW-1:0], cell_x[XW-1:0]};
                ram_wdata = 1'b1;
            end
            ST_IDLE:
            begin
                ram_en = in_beat && (op_t'(s_tuser) == OP_QUERY);
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    ogcf_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        map_width_next  = map_width_reg;
        map_height_next = map_height_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        r_next          = r_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        dx_sq_next      = dx_sq_reg;
        dy_sq_next      = dy_sq_reg;
        rsq_next        = rsq_reg;
        is_draw_next    = is_draw_reg;
        in_bounds_next  = in_bounds_reg;
        out_occ_next    = out_occ_reg;
        out_inb_next    = out_inb_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_MAP_WIDTH:  map_width_next  = cfg_data;
                CFG_MAP_HEIGHT: map_height_next = cfg_data;
                default:        map_width_next  = map_width_reg;
            endcase
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    cx_next        = in_xs;
                    cy_next        = in_ys;
                    r_next         = r_sat;
                    dx_next        = -$signed({1'b0, r_sat});
                    dy_next        = -$signed({1'b0, r_sat});
                    dx_sq_next     = rsq_in;
                    dy_sq_next     = rsq_in;
                    rsq_next       = rsq_in;
                    in_bounds_next = center_in;
                    is_draw_next   = (op_t'(s_tuser) == OP_DRAW);
                    state_next     = (op_t'(s_tuser) == OP_DRAW) ? ST_DRAW : ST_RESP;
                end
            end
            ST_DRAW:
            begin
                // Column-inner scan over the bounding square
                if (!dy_last)
                begin
                    dy_next    = dy_reg + D_W'(1);
                    dy_sq_next = sq_step(dy_sq_reg, dy_reg);
                end
                else
                begin
                    dy_next    = -r_signed;
                    dy_sq_next = rsq_reg;
                    if (dx_last)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        dx_next    = dx_reg + D_W'(1);
                        dx_sq_next = sq_step(dx_sq_reg, dx_reg);
                    end
                end
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_occ_next   = !is_draw_reg && in_bounds_reg && ram_rdata[0];
                    out_inb_next   = in_bounds_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            map_width_reg  <= MAP_WIDTH_RST;
            map_height_reg <= MAP_HEIGHT_RST;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
            map_width_reg  <= map_width_next;
            map_height_reg <= map_height_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        r_reg         <= r_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        dx_sq_reg     <= dx_sq_next;
        dy_sq_reg     <= dy_sq_next;
        rsq_reg       <= rsq_next;
        is_draw_reg   <= is_draw_next;
        in_bounds_reg <= in_bounds_next;
        out_occ_reg   <= out_occ_next;
        out_inb_reg   <= out_inb_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, out_inb_reg, out_occ_reg};

    // Map is only written by the clearing pass or a draw scan
    a_ram_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_DRAW || state_reg == ST_CLEAR))
        else $error("map written outside clear or draw");

    // Every accepted beat starts a draw scan or goes straight to the result
    a_beat_to_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_DRAW || state_reg == ST_RESP))
        else $error("accepted beat not dispatched");

    // Scan offsets never run past the radius
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) |-> (dx_reg <= r_signed && dy_reg <= r_signed))
        else $error("draw scan out of range");

    // An occupied answer always refers to a cell in the map
    a_occ_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[1])
        else $error("occupied reported for out-of-map cell");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the occupancy grid circle fill unit: stream stimulus checked against a shadow map.
`timescale 1ns / 100ps

module tb_top;
    import ogcf_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYC   = 12;
    localparam int MAP_COLS    = DEF_MAP_MAX_WIDTH;
    localparam int MAP_ROWS    = DEF_MAP_MAX_HEIGHT;
    localparam int RADIUS_CAP  = DEF_MAX_RADIUS;
    // Watchdog budget: many times the slowest expected run, such as the reset clearing
    // pass or a full-size disc.
    localparam int LIMIT_CYC   = 3_000_000;
    localparam int TAIL_CYC    = 8;     // tail wait after the final drain
    localparam int HOLD_CYC    = 400;   // long receiver hold-off for the pressure test
    localparam int CHUNK_ITEMS = 110;   // random beats between map-size changes
    localparam int CHUNKS      = 4;     // map-size changes per idle regime
    localparam int RECENT_MAX  = 8;     // discs remembered for aiming queries

    // One input beat and one result beat, as the predictor sees them.
    typedef struct packed {
        op_t                         op;
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic        [RADIUS_W-1:0]  radius;
    } grid_cmd_t;

    typedef struct packed {
        logic in_bounds;
        logic occupied;
    } cell_answer_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // x_coord[9:0], y_coord[19:10], radius[25:20]
    logic [S_TUSER_W-1:0]  s_tuser;    // operation[0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // occupied[0], in_bounds[1]

    occupancy_grid_circle_fill_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Shadow state: map bits plus the two size registers
    // ------------------------------------------------------------------
    bit               shadow_grid [0:MAP_COLS*MAP_ROWS-1];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    cell_answer_t     pending_answers[$];   // answers owed by the block, oldest first
    grid_cmd_t        recent_discs[$];      // last few draws, used to aim queries

    int               mismatch_count;
    int               beats_seen;
    int               cycle_count;

    // Idle knobs, percent of cycles
    int               src_gap_pct;
    int               sink_stall_pct;

    // Long hold-off: test bumps the trigger, the receiver process does the counting
    int               hold_trigger;
    int               hold_seen;
    int               hold_left;

    cell_answer_t     seen_answer;
    cell_answer_t     due_answer;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT_CYC)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Register values past the physical map saturate.
    function automatic int dim_in_use(input logic [DIM_W-1:0] v, input int cap);
        return (int'(v) > cap) ? cap : int'(v);
    endfunction

    function automatic bit on_map(input int x, input int y);
        return x >= 0 && y >= 0 && x < dim_in_use(width_reg, MAP_COLS)
            && y < dim_in_use(height_reg, MAP_ROWS);
    endfunction

    // Applies one command to the shadow map and returns the answer it owes.
    function automatic cell_answer_t grid_apply(input grid_cmd_t cmd);
        int           cx;
        int           cy;
        int           rad;
        int           dx;
        int           dy;
        cell_answer_t ans;
        cx  = $signed(cmd.x);
        cy  = $signed(cmd.y);
        rad = int'(cmd.radius);
        if (rad > RADIUS_CAP)
            rad = RADIUS_CAP;
        ans.in_bounds = on_map(cx, cy);
        ans.occupied  = 1'b0;
        if (cmd.op == OP_DRAW)
        begin
            // Off-map cells are dropped, never stored
            for (dx = -rad; dx <= rad; dx++)
                for (dy = -rad; dy <= rad; dy++)
                    if (dx * dx + dy * dy <= rad * rad && on_map(cx + dx, cy + dy))
                        shadow_grid[(cy + dy) * MAP_COLS + cx + dx] = 1'b1;
        end
        else if (ans.in_bounds)
        begin
            ans.occupied = shadow_grid[cy * MAP_COLS + cx];
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] to_coord(input int v);
        if (v < -512)
            v = -512;
        if (v > 511)
            v = 511;
        return v[COORD_W-1:0];
    endfunction

    function automatic grid_cmd_t mk_cmd(input op_t op, input int x, input int y, input int r);
        grid_cmd_t cmd;
        cmd.op     = op;
        cmd.x      = to_coord(x);
        cmd.y      = to_coord(y);
        cmd.radius = RADIUS_W'(r);
        return cmd;
    endfunction

    // Mostly small discs near the map, queries aimed at recent discs, some noise anywhere.
    function automatic grid_cmd_t pick_cmd();
        grid_cmd_t cmd;
        grid_cmd_t near;
        int        w;
        int        h;
        int        roll;
        int        rsel;
        int        span;
        w    = dim_in_use(width_reg, MAP_COLS);
        h    = dim_in_use(height_reg, MAP_ROWS);
        roll = $urandom_range(99);
        if (roll < 40)
        begin
            cmd.op = OP_DRAW;
            if ($urandom_range(4) == 0)
            begin
                cmd.x = COORD_W'($urandom());
                cmd.y = COORD_W'($urandom());
            end
            else
            begin
                cmd.x = to_coord(int'($urandom_range(w + 15)) - 8);
                cmd.y = to_coord(int'($urandom_range(h + 15)) - 8);
            end
            // Big discs scan (2r+1)^2 cells, so keep them rare
            rsel = $urandom_range(99);
            if (rsel < 85)
                cmd.radius = RADIUS_W'($urandom_range(4));
            else if (rsel < 97)
                cmd.radius = RADIUS_W'($urandom_range(15, 5));
            else
                cmd.radius = RADIUS_W'($urandom_range(63, 16));
            recent_discs.push_back(cmd);
            if (recent_discs.size() > RECENT_MAX)
                void'(recent_discs.pop_front());
        end
        else
        begin
            cmd.op     = OP_QUERY;
            cmd.radius = RADIUS_W'($urandom());   // ignored by queries, still toggled
            if (roll < 75 && recent_discs.size() != 0)
            begin
                near  = recent_discs[$urandom_range(recent_discs.size() - 1)];
                span  = int'(near.radius) + 2;
                cmd.x = to_coord($signed(near.x) + int'($urandom_range(2 * span)) - span);
                cmd.y = to_coord($signed(near.y) + int'($urandom_range(2 * span)) - span);
            end
            else if (roll < 90)
            begin
                cmd.x = to_coord(int'($urandom_range(w + 7)) - 4);
                cmd.y = to_coord(int'($urandom_range(h + 7)) - 4);
            end
            else
            begin
                cmd.x = COORD_W'($urandom());
                cmd.y = COORD_W'($urandom());
            end
        end
        return cmd;
    endfunction

    // Map sizes: mostly in range, with zero, one, full and past-full mixed in.
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DIM_W'($urandom_range(511, 257));
            2:       return DIM_W'(1);
            3:       return DIM_W'(256);
            default: return DIM_W'($urandom_range(255, 2));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offers one beat; returns at the edge that accepts it. tvalid stays high until the
    // next call or a drain lowers it.
    task automatic send_cmd(input grid_cmd_t cmd);
        logic [S_TDATA_W-1:0] word;
        word                      = '0;
        word[X_LSB +: COORD_W]    = cmd.x;
        word[Y_LSB +: COORD_W]    = cmd.y;
        word[R_LSB +: RADIUS_W]   = cmd.radius;
        @(negedge clk);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_answers.push_back(grid_apply(cmd));
    endtask

    // Stop offering and wait until every owed answer is back.
    task automatic drain_answers();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MAP_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic resize_map(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        drain_answers();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an on-demand long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYC - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready  <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result beat %0d: %s got %0d want %0d", beats_seen, what, got,
                 want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_answer.occupied  = m_tdata[0];
            seen_answer.in_bounds = m_tdata[1];
            if (pending_answers.size() == 0)
            begin
                report_mismatch("unexpected beat, data", int'(m_tdata), -1);
            end
            else
            begin
                due_answer = pending_answers.pop_front();
                if (seen_answer.occupied !== due_answer.occupied)
                    report_mismatch("occupied", seen_answer.occupied, due_answer.occupied);
                if (seen_answer.in_bounds !== due_answer.in_bounds)
                    report_mismatch("in_bounds", seen_answer.in_bounds, due_answer.in_bounds);
            end
            beats_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Fresh map: everything free, corners and coordinate extremes.
    task automatic test_cleared_map();
        send_cmd(mk_cmd(OP_QUERY, 0, 0, 0));
        send_cmd(mk_cmd(OP_QUERY, 255, 255, 63));
        send_cmd(mk_cmd(OP_QUERY, -512, -512, 0));
        send_cmd(mk_cmd(OP_QUERY, 511, 511, 0));
    endtask

    // Single-cell disc, full-radius disc clipped by the corner, off-map disc, edge clip.
    task automatic test_disc_shapes();
        send_cmd(mk_cmd(OP_DRAW, 0, 0, 0));
        send_cmd(mk_cmd(OP_QUERY, 0, 0, 0));
        send_cmd(mk_cmd(OP_QUERY, 1, 0, 0));
        send_cmd(mk_cmd(OP_DRAW, -40, 300, 63));
        send_cmd(mk_cmd(OP_QUERY, 0, 255, 0));     // inside the rim
        send_cmd(mk_cmd(OP_QUERY, 5, 255, 0));     // just outside the rim
        send_cmd(mk_cmd(OP_DRAW, 511, -512, 7));   // nothing lands on the map
        send_cmd(mk_cmd(OP_DRAW, 250, 5, 10));     // right edge clips
        send_cmd(mk_cmd(OP_QUERY, 255, 5, 0));
    endtask

    // Empty map, saturated sizes, 1x1 map, regrow and shrink after drawing.
    task automatic test_map_resize();
        resize_map('0, '0);
        send_cmd(mk_cmd(OP_QUERY, 0, 0, 0));
        send_cmd(mk_cmd(OP_DRAW, 100, 100, 1));
        resize_map(DIM_W'(511), DIM_W'(300));
        send_cmd(mk_cmd(OP_QUERY, 255, 255, 0));
        send_cmd(mk_cmd(OP_QUERY, 256, 3, 0));
        resize_map(DIM_W'(1), DIM_W'(1));
        send_cmd(mk_cmd(OP_DRAW, 0, 0, 2));        // only the origin survives
        send_cmd(mk_cmd(OP_QUERY, 0, 0, 0));
        send_cmd(mk_cmd(OP_QUERY, 1, 0, 0));
        resize_map(DIM_W'(256), DIM_W'(256));
        send_cmd(mk_cmd(OP_QUERY, 0, 1, 0));       // dropped earlier, still free
        resize_map(DIM_W'(100), DIM_W'(100));
        send_cmd(mk_cmd(OP_QUERY, 0, 255, 0));     // drawn, now off the map
        resize_map(MAP_WIDTH_RST, MAP_HEIGHT_RST);
    endtask

    // Three idle regimes; map size changes between chunks.
    task automatic test_random_traffic();
        int gap_pct   [3] = '{20, 51, 0};
        int stall_pct [3] = '{51, 20, 0};
        int regime;
        int chunk;
        int n;
        for (regime = 0; regime < 3; regime++)
        begin
            src_gap_pct    = gap_pct[regime];
            sink_stall_pct = stall_pct[regime];
            for (chunk = 0; chunk < CHUNKS; chunk++)
            begin
                resize_map(pick_dim(), pick_dim());
                recent_discs.delete();
                for (n = 0; n < CHUNK_ITEMS; n++)
                    send_cmd(pick_cmd());
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input must stall;
    // then the sender pauses until everything is back and sends a second batch.
    task automatic test_output_backpressure();
        int n;
        resize_map(DIM_W'(256), DIM_W'(256));
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        @(posedge clk);
        hold_trigger++;
        for (n = 0; n < 60; n++)
            send_cmd(pick_cmd());
        drain_answers();
        for (n = 0; n < 20; n++)
            send_cmd(pick_cmd());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_MAP_WIDTH;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_QUERY;
        m_tready       = 1'b0;
        mismatch_count = 0;
        beats_seen     = 0;
        cycle_count    = 0;
        hold_trigger   = 0;
        hold_seen      = 0;
        hold_left      = 0;
        src_gap_pct    = 20;
        sink_stall_pct = 51;
        width_reg      = MAP_WIDTH_RST;
        height_reg     = MAP_HEIGHT_RST;
        foreach (shadow_grid[i])
            shadow_grid[i] = 1'b0;

        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // First beats wait out the clearing pass via tready
        test_cleared_map();
        test_disc_shapes();
        test_map_resize();
        test_random_traffic();
        test_output_backpressure();

        drain_answers();
        repeat (TAIL_CYC) @(posedge clk);
        if (pending_answers.size() != 0)
            report_mismatch("answers never returned", 0, pending_answers.size());

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
